>>> rtl/core/dsfd_pkg.sv
// dsfd_pkg: shared constants and types for the dle shielded frame deframer
package dsfd_pkg;

    localparam int unsigned MAX_FRAME   = 256;
    localparam logic [7:0]  FRAME_LIMIT = 8'(MAX_FRAME - 5);

    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [7:0]  DLE_BYTE  = 8'h10;
    localparam logic [7:0]  ETX_BYTE  = 8'h03;
    localparam logic [7:0]  SUB_BYTE  = 8'h1A;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_DATA     = 2'd0;
    localparam kind_t KIND_END      = 2'd1;
    localparam kind_t KIND_OVERFLOW = 2'd2;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] frame_length;
        logic       last;
    } dsfd_res_t;

endpackage

>>> rtl/core/dsfd_decode.sv
// dsfd_decode: frame state and unshielding of one registered link byte
module dsfd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_vld,
    input  logic [7:0]        in_byte,
    input  logic              out_free,
    output logic              take,
    output logic              res_vld,
    output dsfd_pkg::dsfd_res_t res
);
    import dsfd_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic       after_escape_reg, after_escape_next;
    logic       second_reg, second_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] count_inc;

    assign count_inc = byte_count_reg + 8'd1;

    always_comb begin
        in_frame_next     = in_frame_reg;
        after_escape_next = after_escape_reg;
        second_next       = second_reg;
        byte_count_next   = byte_count_reg;
        take              = 1'b0;
        res_vld           = 1'b0;
        res.kind          = KIND_DATA;
        res.data_byte     = 8'd0;
        res.frame_length  = byte_count_reg;
        res.last          = 1'b1;
        if (in_vld && out_free) begin
            take = 1'b1;
            priority if (second_reg) begin
                // second dle of an escaped sub
                res_vld           = 1'b1;
                res.data_byte     = DLE_BYTE;
                res.frame_length  = count_inc;
                byte_count_next   = count_inc;
                second_next       = 1'b0;
                after_escape_next = 1'b0;
            end else if (!in_frame_reg) begin
                if (in_byte == SYNC_BYTE) begin
                    in_frame_next     = 1'b1;
                    after_escape_next = 1'b0;
                    byte_count_next   = 8'd0;
                end
            end else if (byte_count_reg >= FRAME_LIMIT) begin
                res_vld           = 1'b1;
                res.kind          = KIND_OVERFLOW;
                in_frame_next     = 1'b0;
                after_escape_next = 1'b0;
                byte_count_next   = 8'd0;
            end else if (after_escape_reg) begin
                after_escape_next = 1'b0;
                priority if (in_byte == DLE_BYTE) begin
                    res_vld          = 1'b1;
                    res.data_byte    = DLE_BYTE;
                    res.frame_length = count_inc;
                    byte_count_next  = count_inc;
                end else if (in_byte == SUB_BYTE) begin
                    // first dle now, hold the item for the second
                    take              = 1'b0;
                    res_vld           = 1'b1;
                    res.data_byte     = DLE_BYTE;
                    res.frame_length  = count_inc;
                    res.last          = 1'b0;
                    byte_count_next   = count_inc;
                    second_next       = 1'b1;
                    after_escape_next = 1'b1;
                end else if (in_byte == ETX_BYTE) begin
                    res_vld         = 1'b1;
                    res.kind        = KIND_END;
                    in_frame_next   = 1'b0;
                    byte_count_next = 8'd0;
                end else begin
                end
            end else if (in_byte == DLE_BYTE) begin
                after_escape_next = 1'b1;
            end else begin
                res_vld          = 1'b1;
                res.data_byte    = in_byte;
                res.frame_length = count_inc;
                byte_count_next  = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg     <= 1'b0;
            after_escape_reg <= 1'b0;
            second_reg       <= 1'b0;
            byte_count_reg   <= 8'd0;
        end else begin
            in_frame_reg     <= in_frame_next;
            after_escape_reg <= after_escape_next;
            second_reg       <= second_next;
            byte_count_reg   <= byte_count_next;
        end
    end

endmodule

>>> rtl/core/dsfd_out.sv
// dsfd_out: result register towards the master side
module dsfd_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_vld,
    input  dsfd_pkg::dsfd_res_t res,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import dsfd_pkg::*;

    logic      valid_reg;
    dsfd_res_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_vld) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.frame_length, res_reg.data_byte};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

>>> rtl/core/dle_shielded_frame_deframer.sv
// dle_shielded_frame_deframer: top level, input register, decoder and result register
// a link byte accepted into the input register is decoded combinationally and its
// first result is captured in the result register towards the master side
// throughput: one link byte per cycle unless stalled; an escaped sub gives two items
// the result register frees each cycle the master side takes an item
// reset: synchronous on aresetn low, hunts for sync with count and escape flag cleared
module dle_shielded_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // frame_length [15:8], data_byte [7:0]
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import dsfd_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       take;
    logic       out_free;
    logic       res_vld;
    dsfd_res_t  res;

    assign s_tready = !in_vld_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    dsfd_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (in_vld_reg),
        .in_byte  (in_byte_reg),
        .out_free (out_free),
        .take     (take),
        .res_vld  (res_vld),
        .res      (res)
    );

    dsfd_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_vld  (res_vld),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/tb_dle_shielded_frame_deframer.sv
// tb_dle_shielded_frame_deframer: random and directed stream test of the deframer with a local predictor
module tb_dle_shielded_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import dsfd_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // frame_length [15:8], data_byte [7:0]
    logic [1:0]  m_tuser;           // kind
    logic        m_tlast;

    dle_shielded_frame_deframer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    logic [7:0] link_bytes[$];
    dsfd_res_t  expected_items[$];

    // predictor state
    logic       in_frame_q = 1'b0;
    logic       escape_q = 1'b0;
    logic [7:0] count_q = 8'd0;

    int  mismatches = 0;
    bit  s_fire = 1'b0;
    bit  m_fire = 1'b0;
    bit  s_busy = 1'b0;
    int  s_gap = 0;
    int  r_gap = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;
    bit  random_started = 1'b0;
    logic [7:0] cur_byte = 8'h00;

    function automatic void push_result(input kind_t k, input logic [7:0] d,
                                        input logic [7:0] len, input logic lst);
        dsfd_res_t r;
        r.kind = k;
        r.data_byte = d;
        r.frame_length = len;
        r.last = lst;
        expected_items.push_back(r);
    endfunction

    function automatic void push_data(input logic [7:0] d, input logic lst);
        count_q = count_q + 8'd1;
        push_result(KIND_DATA, d, count_q, lst);
    endfunction

    function automatic void deframe_byte(input logic [7:0] c);
        if (!in_frame_q) begin
            if (c == SYNC_BYTE) begin
                in_frame_q = 1'b1;
                escape_q = 1'b0;
                count_q = 8'd0;
            end
        end else if (count_q >= FRAME_LIMIT) begin
            push_result(KIND_OVERFLOW, 8'h00, count_q, 1'b1);
            in_frame_q = 1'b0;
            escape_q = 1'b0;
            count_q = 8'd0;
        end else if (escape_q) begin
            escape_q = 1'b0;
            case (c)
                DLE_BYTE: push_data(DLE_BYTE, 1'b1);
                SUB_BYTE: begin
                    push_data(DLE_BYTE, 1'b0);
                    push_data(DLE_BYTE, 1'b1);
                end
                ETX_BYTE: begin
                    push_result(KIND_END, 8'h00, count_q, 1'b1);
                    in_frame_q = 1'b0;
                    count_q = 8'd0;
                end
                default: ;
            endcase
        end else if (c == DLE_BYTE) begin
            escape_q = 1'b1;
        end else begin
            push_data(c, 1'b1);
        end
    endfunction

    // noise, sync, shielded payload and usually a closing escape
    task automatic queue_frame(input bit long_frame);
        int n;
        int pick;
        logic [7:0] b;
        repeat ($urandom_range(0, 3)) link_bytes.push_back(8'($urandom_range(0, 254)));
        link_bytes.push_back(SYNC_BYTE);
        n = long_frame ? $urandom_range(240, 262) : $urandom_range(0, 20);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                link_bytes.push_back(DLE_BYTE);
                link_bytes.push_back(DLE_BYTE);
            end else if (pick == 1) begin
                link_bytes.push_back(DLE_BYTE);
                link_bytes.push_back(SUB_BYTE);
            end else if (pick == 2) begin
                b = 8'($urandom);
                while (b == DLE_BYTE || b == SUB_BYTE || b == ETX_BYTE) b = 8'($urandom);
                link_bytes.push_back(DLE_BYTE);
                link_bytes.push_back(b);
            end else begin
                b = 8'($urandom);
                if (b == DLE_BYTE) link_bytes.push_back(DLE_BYTE);
                link_bytes.push_back(b);
            end
        end
        if ($urandom_range(0, 7) != 0) begin
            link_bytes.push_back(DLE_BYTE);
            link_bytes.push_back(ETX_BYTE);
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb_dle_shielded_frame_deframer: errors");
        $finish;
    end

    // stretches without idling on either side
    initial begin
        forever begin
            repeat ($urandom_range(50, 300)) @(posedge aclk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    // long receiver hold-offs while the sender keeps offering
    initial begin
        while (!random_started) @(posedge aclk);
        repeat (2) begin
            repeat (300) @(posedge aclk);
            hold_off = 1'b1;
            repeat (600) @(posedge aclk);
            hold_off = 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
        end else begin
            if (s_busy && s_fire) s_busy = 1'b0;
            if (!s_busy) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (link_bytes.size() > 0) begin
                    cur_byte = link_bytes.pop_front();
                    s_busy = 1'b1;
                    s_gap = calm ? 0 : $urandom_range(0, 4);
                end
            end
            s_tvalid <= s_busy;
            s_tdata <= cur_byte;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_fire) r_gap = calm ? 0 : $urandom_range(0, 4);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (r_gap > 0) begin
                r_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : sample
        dsfd_res_t want;
        dsfd_res_t got;
        s_fire = aresetn && s_tvalid && s_tready;
        m_fire = aresetn && m_tvalid && m_tready;
        if (s_fire) deframe_byte(s_tdata);
        if (m_fire) begin
            got.kind = m_tuser;
            got.data_byte = m_tdata[7:0];
            got.frame_length = m_tdata[15:8];
            got.last = m_tlast;
            if (expected_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d data %02h len %0d last %0d",
                             got.kind, got.data_byte, got.frame_length, got.last);
            end else begin
                want = expected_items.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d data %02h len %0d last %0d, got kind %0d data %02h len %0d last %0d",
                                 want.kind, want.data_byte, want.frame_length, want.last,
                                 got.kind, got.data_byte, got.frame_length, got.last);
                end
            end
        end
    end

    initial begin
        int frame_no;
        int target;
        // hunting drops bytes, then every escape and plain corner
        link_bytes = '{8'h00, 8'h10, 8'h03, SYNC_BYTE, 8'hFF, 8'h00,
                       DLE_BYTE, DLE_BYTE, DLE_BYTE, SUB_BYTE, ETX_BYTE, SUB_BYTE,
                       DLE_BYTE, 8'h55, 8'h7F, 8'h80, DLE_BYTE, ETX_BYTE,
                       8'h55, SYNC_BYTE, DLE_BYTE, ETX_BYTE,
                       SYNC_BYTE, 8'hFF, DLE_BYTE, ETX_BYTE};
        target = link_bytes.size() + 1250;
        frame_no = 0;
        while (link_bytes.size() < target) begin
            queue_frame((frame_no % 16) == 5 || $urandom_range(0, 39) == 0);
            frame_no++;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        random_started = 1'b1;
        while (link_bytes.size() != 0 || s_busy) @(posedge aclk);
        while (expected_items.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_items.size() == 0) begin
            $display("tb_dle_shielded_frame_deframer: clean");
        end else begin
            $display("tb_dle_shielded_frame_deframer: errors");
        end
        $finish;
    end

endmodule
